[design/rgbh_pkg.sv]
// Shared constants, types and residual arithmetic for the RGB residual histogram.
`default_nettype none
package rgbh_pkg;
  localparam int MAX_DEPTH  = 8;
  localparam int MAX_WIDTH  = 4096;
  localparam int COUNT_BITS = 32;
  localparam int NUM_CH     = 18;
  localparam int BINS       = 1 << MAX_DEPTH;
  localparam int BIN_BITS   = MAX_DEPTH;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int SMP_BITS   = 8;
  localparam int PIX_BITS   = 3 * SMP_BITS;
  localparam int RES_BITS   = 12;
  localparam int CH_BITS    = 5;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_LB,
    ST_HR,
    ST_RD
  } state_e;

  typedef logic signed [RES_BITS-1:0] res_t;
  typedef logic [BIN_BITS-1:0] bin_t;

  function automatic res_t sx(input logic [SMP_BITS-1:0] v);
    sx = {{(RES_BITS-SMP_BITS){v[SMP_BITS-1]}}, v};
  endfunction

  // halve, rounding toward zero
  function automatic res_t div2(input res_t s);
    res_t t;
    t = s + {{(RES_BITS-1){1'b0}}, s[RES_BITS-1]};
    div2 = t >>> 1;
  endfunction

  function automatic res_t grad(input res_t n, input res_t w, input res_t nw);
    res_t lo, hi, p;
    lo = (n < w) ? n : w;
    hi = (n < w) ? w : n;
    p  = n + w - nw;
    grad = (p < lo) ? lo : ((p > hi) ? hi : p);
  endfunction

  function automatic res_t sat(input res_t x, input res_t half);
    sat = (x < -half) ? -half : ((x > half - 12'sd1) ? half - 12'sd1 : x);
  endfunction

  function automatic bin_t to_bin(input res_t r, input res_t half, input bin_t mask);
    res_t t;
    t = r + half;
    to_bin = t[BIN_BITS-1:0] & mask;
  endfunction
endpackage
`default_nettype wire

[design/rgbh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rgbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[design/rgb_predictor_residual_histogram.sv]
// Top level: line buffer, residual generation and 18 banked residual histograms.
`default_nettype none
// A pixel transaction reads the line buffer, then forms the 18 residual bins and
// reads all histogram banks in parallel, then writes the incremented counts
// back. A read transaction returns its count through the output register once
// that register is free. A clear transaction, and the clearing pass after reset,
// sweep the 256 bins of every bank, during which no transaction is accepted;
// configuration writes are taken at any time. Pixels in the first row and first
// column only fill the buffers.
module rgb_predictor_residual_histogram (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   op_i,
  input  wire logic signed [7:0]            red_i,
  input  wire logic signed [7:0]            green_i,
  input  wire logic signed [7:0]            blue_i,
  input  wire logic [4:0]                   channel_sel_i,
  input  wire logic [7:0]                   bin_sel_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [31:0]                       bin_count_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [12:0]                  cfg_data_i
);
  localparam int CB = rgbh_pkg::COL_BITS;
  localparam int CW = rgbh_pkg::COUNT_BITS;
  localparam int BB = rgbh_pkg::BIN_BITS;
  localparam int NC = rgbh_pkg::NUM_CH;

  rgbh_pkg::state_e state_q, state_d;

  logic [3:0]  depth_q;
  logic [12:0] width_q;
  logic [CB:0] col_q, col_d;
  logic        first_q, first_d;
  logic [rgbh_pkg::PIX_BITS-1:0] cur_q, left_q, al_q;
  logic [BB-1:0] clr_q;
  logic [rgbh_pkg::CH_BITS-1:0] ch_q;
  logic        proc_q;
  rgbh_pkg::bin_t bin_q [NC];
  rgbh_pkg::bin_t bin_c [NC];
  logic        out_valid_q;
  logic [31:0] out_q;

  logic accept;
  logic [3:0] depth_e;
  logic [CB:0] width_e;
  logic [CB:0] col_w;
  logic first_w;
  logic [rgbh_pkg::PIX_BITS-1:0] above;
  logic [CW-1:0] h_rdata [NC];
  logic out_load;
  rgbh_pkg::res_t half;
  rgbh_pkg::bin_t mask;
  logic process;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rgbh_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign bin_count_o = out_q;

  assign depth_e = (depth_q == 4'd0) ? 4'd1 :
                   ((depth_q > 4'(rgbh_pkg::MAX_DEPTH)) ? 4'(rgbh_pkg::MAX_DEPTH) : depth_q);
  assign width_e = (width_q < 13'd2) ? (CB+1)'(2) :
                   ((width_q > 13'(rgbh_pkg::MAX_WIDTH)) ? (CB+1)'(rgbh_pkg::MAX_WIDTH)
                                                         : (CB+1)'(width_q));
  assign half = rgbh_pkg::res_t'(12'sd1 <<< (depth_e - 4'd1));
  assign mask = rgbh_pkg::bin_t'((9'd1 << depth_e) - 9'd1);

  // row wrap as seen when the pixel is taken
  assign col_w   = (col_q >= width_e) ? '0 : col_q;
  assign first_w = (col_q >= width_e) ? 1'b0 : first_q;
  assign process = !first_q && (col_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= 4'd8;
      width_q <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rgbh_pkg::REG_DEPTH: depth_q <= cfg_data_i[3:0];
        rgbh_pkg::REG_WIDTH: width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rgbh_ram #(.WIDTH(rgbh_pkg::PIX_BITS), .DEPTH(rgbh_pkg::MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (state_q == rgbh_pkg::ST_LB),
    .waddr_i (col_q[CB-1:0]),
    .wdata_i (cur_q),
    .re_i    (accept && op_i == rgbh_pkg::OP_PIXEL),
    .raddr_i (col_w[CB-1:0]),
    .rdata_o (above)
  );

  // residual bins from current, above, left and above-left pixels
  always_comb begin
    rgbh_pkg::res_t xv [3];
    rgbh_pkg::res_t nv [3];
    rgbh_pkg::res_t wv [3];
    rgbh_pkg::res_t dv [3];
    rgbh_pkg::res_t dn, dw, dd;
    for (int c = 0; c < 3; c++) begin
      xv[c] = rgbh_pkg::sx(cur_q[(2-c)*8 +: 8]);
      nv[c] = rgbh_pkg::sx(above[(2-c)*8 +: 8]);
      wv[c] = rgbh_pkg::sx(left_q[(2-c)*8 +: 8]);
      dv[c] = rgbh_pkg::sx(al_q[(2-c)*8 +: 8]);
    end
    // own predictions: g (1) at 0, b (2) at 3, r (0) at 9
    for (int k = 0; k < 3; k++) begin
      int t, ch;
      t  = (k == 0) ? 1 : ((k == 1) ? 2 : 0);
      ch = (k == 0) ? 0 : ((k == 1) ? 3 : 9);
      bin_c[ch]   = rgbh_pkg::to_bin(xv[t], half, mask);
      bin_c[ch+1] = rgbh_pkg::to_bin(xv[t] - rgbh_pkg::div2(nv[t] + wv[t]), half, mask);
      bin_c[ch+2] = rgbh_pkg::to_bin(xv[t] - rgbh_pkg::grad(nv[t], wv[t], dv[t]),
                                     half, mask);
    end
    // cross predictions: b-g at 6, r-g at 12, r-b at 15
    for (int k = 0; k < 3; k++) begin
      int t, b, ch;
      t  = (k == 0) ? 2 : 0;
      b  = (k == 2) ? 2 : 1;
      ch = (k == 0) ? 6 : ((k == 1) ? 12 : 15);
      dn = nv[t] - nv[b];
      dw = wv[t] - wv[b];
      dd = dv[t] - dv[b];
      bin_c[ch]   = rgbh_pkg::to_bin(xv[t] - xv[b], half, mask);
      bin_c[ch+1] = rgbh_pkg::to_bin(
        xv[t] - rgbh_pkg::sat(rgbh_pkg::div2(dn + dw) + xv[b], half), half, mask);
      bin_c[ch+2] = rgbh_pkg::to_bin(
        xv[t] - rgbh_pkg::sat(rgbh_pkg::grad(dn, dw, dd) + xv[b], half), half, mask);
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_bank
    logic          re, we;
    logic [BB-1:0] raddr, waddr;
    logic [CW-1:0] wdata;
    assign re    = ((state_q == rgbh_pkg::ST_LB) && process) ||
                   (accept && op_i == rgbh_pkg::OP_READ &&
                    channel_sel_i == rgbh_pkg::CH_BITS'(k));
    assign raddr = (state_q == rgbh_pkg::ST_LB) ? bin_c[k] : bin_sel_i;
    assign we    = (state_q == rgbh_pkg::ST_CLR) || ((state_q == rgbh_pkg::ST_HR) && proc_q);
    assign waddr = (state_q == rgbh_pkg::ST_CLR) ? clr_q : bin_q[k];
    assign wdata = (state_q == rgbh_pkg::ST_CLR) ? '0 :
                   ((&h_rdata[k]) ? h_rdata[k] : h_rdata[k] + CW'(1));
    rgbh_ram #(.WIDTH(CW), .DEPTH(rgbh_pkg::BINS)) u_hist (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (re),
      .raddr_i (raddr),
      .rdata_o (h_rdata[k])
    );
  end

  assign out_load = (state_q == rgbh_pkg::ST_RD) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    first_d = first_q;
    unique case (state_q)
      rgbh_pkg::ST_CLR: begin
        if (clr_q == BB'(rgbh_pkg::BINS - 1)) state_d = rgbh_pkg::ST_IDLE;
      end
      rgbh_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_i)
            rgbh_pkg::OP_PIXEL: begin
              state_d = rgbh_pkg::ST_LB;
              col_d   = col_w;
              first_d = first_w;
            end
            rgbh_pkg::OP_READ:  state_d = rgbh_pkg::ST_RD;
            rgbh_pkg::OP_CLEAR: begin
              state_d = rgbh_pkg::ST_CLR;
              col_d   = '0;
              first_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      rgbh_pkg::ST_LB: begin
        state_d = rgbh_pkg::ST_HR;
        col_d   = col_q + (CB+1)'(1);
        if (col_q + (CB+1)'(1) >= width_e) begin
          col_d   = '0;
          first_d = 1'b0;
        end
      end
      rgbh_pkg::ST_HR: state_d = rgbh_pkg::ST_IDLE;
      rgbh_pkg::ST_RD: if (out_load) state_d = rgbh_pkg::ST_IDLE;
      default: state_d = rgbh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgbh_pkg::ST_CLR;
      col_q       <= '0;
      first_q     <= 1'b1;
      clr_q       <= '0;
      proc_q      <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      al_q        <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      first_q <= first_d;
      if (state_q == rgbh_pkg::ST_CLR) clr_q <= clr_q + BB'(1);
      if (state_q == rgbh_pkg::ST_LB) begin
        proc_q <= process;
        left_q <= cur_q;
        al_q   <= above;
      end
      if (accept && op_i == rgbh_pkg::OP_CLEAR) begin
        left_q <= '0;
        al_q   <= '0;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q <= {red_i, green_i, blue_i};
      ch_q  <= channel_sel_i;
    end
    if (state_q == rgbh_pkg::ST_LB) begin
      for (int k = 0; k < NC; k++) bin_q[k] <= bin_c[k];
    end
    if (out_load) begin
      if (ch_q < rgbh_pkg::CH_BITS'(NC)) out_q <= 32'(h_rdata[ch_q]);
      else out_q <= '0;
    end
  end
endmodule
`default_nettype wire

[design/rgbh_checker.sv]
// Port-level checker for the RGB residual histogram and its bind.
`default_nettype none
module rgbh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  op_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] bin_count_o
);
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_count_o))
    else $error("stalled result transaction changed");

  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op_i == rgbh_pkg::OP_PIXEL |=> in_stall_o)
    else $error("pixel transaction did not occupy the block");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op_i == rgbh_pkg::OP_CLEAR |=> in_stall_o ##1 in_stall_o)
    else $error("clear did not hold off transactions");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op_i == rgbh_pkg::OP_READ && !out_valid_o |=> ##1 out_valid_o)
    else $error("read result late");
endmodule

bind rgb_predictor_residual_histogram rgbh_checker u_rgbh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .bin_count_o (bin_count_o)
);
`default_nettype wire
